FILE: rtl/ir_beacon_frame_transmitter_assert.svh
// Assertion macros used by the infrared beacon transmitter serializer, irb_back.
// Depends on nothing; the macro bodies are empty when SYNTHESIS is defined.
`ifndef IR_BEACON_FRAME_TRANSMITTER_ASSERT_SVH
`define IR_BEACON_FRAME_TRANSMITTER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define IRB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irb assertion failed");
// Next-cycle implication, checked outside reset.
`define IRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irb assertion failed");
`else
`define IRB_ASSERT_NOW(label, clk, rst, ante, cons)
`define IRB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/irb_pkg.sv
// Types and constants of the infrared beacon frame transmitter.
// Used by every module of the block but irb_fifo; depends on nothing.
package irb_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] current_sample;
    logic [11:0] voltage_sample;
  } req_t;

  typedef struct packed {
    logic [15:0] mark_us;
    logic [15:0] space_us;
    logic        last_pair;
  } pair_t;

  // Pulse timing registers as seen by the serializer.
  typedef struct packed {
    logic [15:0] leader_mark_us;
    logic [15:0] leader_space_us;
    logic [15:0] bit_mark_us;
    logic [15:0] one_space_us;
    logic [15:0] zero_space_us;
  } timing_t;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd5;

  // Register reset values.
  localparam logic [31:0] DEVICE_ID_RST    = 32'd8;
  localparam logic [15:0] LEADER_MARK_RST  = 16'd9000;
  localparam logic [15:0] LEADER_SPACE_RST = 16'd4500;
  localparam logic [15:0] BIT_MARK_RST     = 16'd560;
  localparam logic [15:0] ONE_SPACE_RST    = 16'd1680;
  localparam logic [15:0] ZERO_SPACE_RST   = 16'd560;

  // Frame kinds; code 3 is treated as a measurement frame.
  localparam logic [1:0] OP_ID_ONE  = 2'd0;
  localparam logic [1:0] OP_ID_TWO  = 2'd1;
  localparam logic [1:0] OP_MEASURE = 2'd2;

  localparam logic [7:0] HDR_ID_ONE  = 8'h33;
  localparam logic [7:0] HDR_ID_TWO  = 8'h39;
  localparam logic [7:0] HDR_MEASURE = 8'hC0;

  // One leader pair, 32 bit pairs, one stop pair.
  localparam int unsigned PAIRS_PER_FRAME = 34;
  localparam int unsigned STEP_W          = 6;
  localparam logic [STEP_W-1:0] STEP_LEADER = 6'd0;
  localparam logic [STEP_W-1:0] STEP_STOP   = 6'(PAIRS_PER_FRAME - 1);

endpackage

FILE: rtl/ir_beacon_frame_transmitter.sv
// Top level of the infrared beacon frame transmitter.
// Depends on irb_pkg, irb_front, irb_fifo and irb_back.

// A request is taken at a clock edge where start is high and busy is low. Each
// request produces exactly 34 mark/space words on pair, one per cycle, each
// marked by pair_valid for a single cycle: the leader pair, 32 bit pairs with
// the most significant frame bit first, and a stop pair with zero space and
// last_pair set. The receiver cannot hold words off, so it must take one every
// cycle while pair_valid is high. When the serializer is idle, the first word
// of a frame follows its request through the queue, the serializer state
// register and the pair register. The serializer sends one pair per cycle and
// sets the rate, so frames of back-to-back requests follow each other with no
// gap. A queue of QUEUE_DEPTH frame words sits between the request
// side and the serializer, so up to that many requests can be taken while a
// frame is being sent; busy is high only while the queue is full. Registers
// are written through cfg_we, cfg_index and cfg_data and should only change
// while no frame is pending or being sent; the frame word of a request is built
// from device_id at the moment it is taken, the pulse times are read while the
// pairs are sent. Writes to indexes beyond the register list are ignored.
module ir_beacon_frame_transmitter import irb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  pair_valid,
  output pair_t                 pair,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [31:0] device_id;
  timing_t     timing;

  // Queue signals between the front end and the serializer.
  logic              push;
  logic [WORD_W-1:0] push_word;
  logic              pop;
  logic [WORD_W-1:0] pop_word;
  logic              full;
  logic              empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id              <= DEVICE_ID_RST;
      timing.leader_mark_us  <= LEADER_MARK_RST;
      timing.leader_space_us <= LEADER_SPACE_RST;
      timing.bit_mark_us     <= BIT_MARK_RST;
      timing.one_space_us    <= ONE_SPACE_RST;
      timing.zero_space_us   <= ZERO_SPACE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEVICE_ID:    device_id              <= cfg_data;
        REG_LEADER_MARK:  timing.leader_mark_us  <= cfg_data[15:0];
        REG_LEADER_SPACE: timing.leader_space_us <= cfg_data[15:0];
        REG_BIT_MARK:     timing.bit_mark_us     <= cfg_data[15:0];
        REG_ONE_SPACE:    timing.one_space_us    <= cfg_data[15:0];
        REG_ZERO_SPACE:   timing.zero_space_us   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The request side is only held off by a full queue.
  assign busy = full;

  irb_front u_front (
    .start     (start),
    .full      (full),
    .req       (req),
    .device_id (device_id),
    .push      (push),
    .word      (push_word)
  );

  irb_fifo #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_word),
    .pop       (pop),
    .pop_data  (pop_word),
    .full      (full),
    .empty     (empty)
  );

  irb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .timing     (timing),
    .empty      (empty),
    .word       (pop_word),
    .pop        (pop),
    .pair_valid (pair_valid),
    .pair       (pair)
  );

endmodule

FILE: rtl/irb_front.sv
// Request front end: takes a frame request and builds its 32-bit frame word.
// Depends on irb_pkg.
module irb_front import irb_pkg::*; (
  input  logic              start,
  input  logic              full,
  input  req_t              req,
  input  logic [31:0]       device_id,
  output logic              push,
  output logic [WORD_W-1:0] word
);

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] id_sum;
  logic [23:0] data;
  logic [7:0]  data_sum;
  logic [7:0]  head;

  assign b0 = device_id[7:0];
  assign b1 = device_id[15:8];
  assign b2 = device_id[23:16];
  assign b3 = device_id[31:24];

  assign id_sum   = 16'(b0) + 16'(b1) + 16'(b2) + 16'(b3);
  assign data     = {req.current_sample, req.voltage_sample};
  assign data_sum = data[7:0] + data[15:8] + data[23:16];
  assign head     = HDR_MEASURE + {4'd0, data_sum[7:4]};

  assign push = start && !full;

  always_comb begin
    case (req.operation)
      OP_ID_ONE: word = {HDR_ID_ONE, b0, b1, b2};
      OP_ID_TWO: word = {HDR_ID_TWO, b3, id_sum};
      default:   word = {head, data};
    endcase
  end

endmodule

FILE: rtl/irb_fifo.sv
// Small queue of frame words between the front end and the serializer.
// Depends on nothing but its parameters.
module irb_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/irb_back.sv
// Serializer: turns queued frame words into 34 mark/space pairs each.
// Depends on irb_pkg and the assertion macro header.
`include "ir_beacon_frame_transmitter_assert.svh"

module irb_back import irb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  timing_t           timing,
  input  logic              empty,
  input  logic [WORD_W-1:0] word,
  output logic              pop,
  output logic              pair_valid,
  output pair_t             pair
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEND = 2'b10
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [WORD_W-1:0] shifter;
  pair_t             pair_next;

  // A new word is taken when idle or on the stop step of the current frame,
  // so frames follow each other without a gap.
  assign pop = !empty && ((state == S_IDLE) || (step == STEP_STOP));

  always_comb begin
    if (step == STEP_LEADER) begin
      pair_next = '{timing.leader_mark_us, timing.leader_space_us, 1'b0};
    end else if (step == STEP_STOP) begin
      pair_next = '{timing.bit_mark_us, 16'd0, 1'b1};
    end else begin
      pair_next = '{timing.bit_mark_us,
                    shifter[WORD_W-1] ? timing.one_space_us : timing.zero_space_us,
                    1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= STEP_LEADER;
      pair_valid <= 1'b0;
    end else begin
      pair_valid <= (state == S_SEND);
      if (pop) begin
        state <= S_SEND;
        step  <= STEP_LEADER;
      end else if (state == S_SEND) begin
        if (step == STEP_STOP) begin
          state <= S_IDLE;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SEND) begin
      pair <= pair_next;
    end
    if (pop) begin
      shifter <= word;
    end else if ((state == S_SEND) && (step != STEP_LEADER)) begin
      shifter <= {shifter[WORD_W-2:0], 1'b0};
    end
  end

  `IRB_ASSERT_NOW(a_stop_has_no_space, clk, rst, pair_valid && pair.last_pair, pair.space_us == 16'd0)
  `IRB_ASSERT_NEXT(a_send_emits, clk, rst, state == S_SEND, pair_valid)
  `IRB_ASSERT_NEXT(a_frame_unbroken, clk, rst, pair_valid && !pair.last_pair, pair_valid)
  `IRB_ASSERT_NOW(a_step_in_range, clk, rst, state == S_SEND, step <= STEP_STOP)

endmodule

FILE: tb/sv/irb_frame_checker.sv
// Scoreboard for the infrared beacon frame transmitter: predicts every mark/space word.
// Depends on irb_pkg; it only watches the block's ports and reports a count of mismatches.
module irb_frame_checker import irb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  req_t                  req,
  input  logic                  pair_valid,
  input  pair_t                 pair,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending_pairs,
  output int                    failures
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] device_id_shadow;
  timing_t     timing_shadow;
  pair_t       expected_pairs[$];
  int          mismatch_count = 0;

  function automatic logic [31:0] frame_word(req_t r);
    logic [7:0]  id_b0, id_b1, id_b2, id_b3;
    logic [15:0] id_sum;
    logic [23:0] sample_bits;
    logic [7:0]  sample_sum;
    logic [7:0]  head;
    {id_b3, id_b2, id_b1, id_b0} = device_id_shadow;
    id_sum = 16'(id_b0) + 16'(id_b1) + 16'(id_b2) + 16'(id_b3);
    sample_bits = {r.current_sample, r.voltage_sample};
    // The header nibble comes from the 8-bit wrapped sum of the three sample bytes.
    sample_sum = sample_bits[7:0] + sample_bits[15:8] + sample_bits[23:16];
    head = HDR_MEASURE + {4'h0, sample_sum[7:4]};
    case (r.operation)
      OP_ID_ONE: frame_word = {HDR_ID_ONE, id_b0, id_b1, id_b2};
      OP_ID_TWO: frame_word = {HDR_ID_TWO, id_b3, id_sum};
      default:   frame_word = {head, sample_bits};
    endcase
  endfunction

  function automatic void queue_frame(req_t r);
    logic [31:0] word;
    pair_t       p;
    word = frame_word(r);
    p.mark_us   = timing_shadow.leader_mark_us;
    p.space_us  = timing_shadow.leader_space_us;
    p.last_pair = 1'b0;
    expected_pairs.push_back(p);
    for (int b = 31; b >= 0; b--) begin
      p.mark_us  = timing_shadow.bit_mark_us;
      p.space_us = word[b] ? timing_shadow.one_space_us : timing_shadow.zero_space_us;
      expected_pairs.push_back(p);
    end
    p.mark_us   = timing_shadow.bit_mark_us;
    p.space_us  = '0;
    p.last_pair = 1'b1;
    expected_pairs.push_back(p);
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    pair_t want;
    if (rst) begin
      device_id_shadow = DEVICE_ID_RST;
      timing_shadow    = '{LEADER_MARK_RST, LEADER_SPACE_RST, BIT_MARK_RST,
                           ONE_SPACE_RST, ZERO_SPACE_RST};
      expected_pairs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEVICE_ID:    device_id_shadow = cfg_data;
          REG_LEADER_MARK:  timing_shadow.leader_mark_us = cfg_data[15:0];
          REG_LEADER_SPACE: timing_shadow.leader_space_us = cfg_data[15:0];
          REG_BIT_MARK:     timing_shadow.bit_mark_us = cfg_data[15:0];
          REG_ONE_SPACE:    timing_shadow.one_space_us = cfg_data[15:0];
          REG_ZERO_SPACE:   timing_shadow.zero_space_us = cfg_data[15:0];
          default: ;
        endcase
      end
      if (pair_valid) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t ns: word with nothing expected, actual mark %0d space %0d last %0d",
                   $time, pair.mark_us, pair.space_us, pair.last_pair);
          mismatch_count++;
        end else begin
          want = expected_pairs.pop_front();
          check_field("mark_us", want.mark_us, pair.mark_us);
          check_field("space_us", want.space_us, pair.space_us);
          check_field("last_pair", 16'(want.last_pair), 16'(pair.last_pair));
        end
      end
      if (start && !busy) queue_frame(req);
    end
    pending_pairs <= expected_pairs.size();
    failures      <= mismatch_count;
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the infrared beacon frame transmitter testbench: clock, reset, stimulus, verdict.
// Depends on irb_pkg, the block ir_beacon_frame_transmitter and the scoreboard irb_frame_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import irb_pkg::*;

  // The package has no name for the spare frame kind or the unused register slots.
  localparam logic [1:0]           OP_SPARE      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // A frame drains without a pause, so any quiet stretch far beyond the longest
  // sender gap means the block has hung.
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE       = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 68;
  localparam int STEADY_PHASE = 2;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  req_t                  req = '0;
  logic                  pair_valid;
  pair_t                 pair;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    pending_pairs;
  int                    failures;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ir_beacon_frame_transmitter DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .pair_valid (pair_valid),
    .pair       (pair),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  irb_frame_checker frame_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .pair_valid    (pair_valid),
    .pair          (pair),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_pairs (pending_pairs),
    .failures      (failures)
  );

  // Offers one request and returns at the edge where it is taken. Start is left
  // high so that a following request goes out back to back; a gap lowers it.
  task automatic send_frame(input logic [1:0] op, input logic [11:0] cur,
                            input logic [11:0] volt);
    req_t r;
    r.operation      = op;
    r.current_sample = cur;
    r.voltage_sample = volt;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  // The sender goes quiet for a while; the request lines carry junk meanwhile.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    req   <= req_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until every predicted word has come out. The scoreboard count is a
  // registered copy, so the first look is at the edge after the last request was taken.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_pairs != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes all six registers while the block is idle. The 16-bit timing
  // registers get junk in their upper half, which the block must drop, and a
  // write to an index past the register list must change nothing.
  task automatic program_regs(input logic [31:0] dev, input logic [15:0] lead_mark,
                              input logic [15:0] lead_space, input logic [15:0] bit_mark,
                              input logic [15:0] one_space, input logic [15:0] zero_space);
    write_reg(REG_DEVICE_ID, dev);
    write_reg(REG_LEADER_MARK, {16'($urandom), lead_mark});
    write_reg(REG_LEADER_SPACE, {16'($urandom), lead_space});
    write_reg(REG_BIT_MARK, {16'($urandom), bit_mark});
    write_reg(REG_ONE_SPACE, {16'($urandom), one_space});
    write_reg(REG_ZERO_SPACE, {16'($urandom), zero_space});
    write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_duration();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_device_id();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 12'h000;
      1:       return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    case ($urandom_range(0, 3))
      0:       return OP_ID_ONE;
      1:       return OP_ID_TWO;
      2:       return OP_MEASURE;
      default: return OP_SPARE;
    endcase
  endfunction

  initial begin : stimulus
    int gap;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset timing first: every frame kind, the spare kind that must behave as
    // a measurement, and samples at both extremes and in checkerboard patterns.
    send_frame(OP_ID_ONE, 12'h000, 12'h000);
    send_frame(OP_ID_TWO, 12'h000, 12'h000);
    send_frame(OP_MEASURE, 12'h000, 12'h000);
    send_frame(OP_MEASURE, 12'hFFF, 12'hFFF);
    send_frame(OP_MEASURE, 12'hAAA, 12'h555);
    send_frame(OP_SPARE, 12'h555, 12'hAAA);
    send_frame(OP_MEASURE, 12'h800, 12'h001);

    // Every register at its largest value; an all-ones identifier drives the
    // identifier checksum to its largest sum.
    wait_drained();
    program_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(OP_ID_ONE, 12'hFFF, 12'hFFF);
    send_frame(OP_ID_TWO, 12'hFFF, 12'hFFF);
    send_frame(OP_MEASURE, 12'hFFF, 12'h000);
    send_frame(OP_SPARE, 12'h000, 12'hFFF);

    // Zero durations must come out as given.
    wait_drained();
    program_regs(32'h0000_0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_frame(OP_ID_ONE, 12'h123, 12'hABC);
    send_frame(OP_ID_TWO, 12'h000, 12'h000);
    send_frame(OP_MEASURE, 12'hFF0, 12'h0FF);
    send_frame(OP_SPARE, 12'hFFF, 12'hFFF);

    // Mixed identifier bytes with distinct durations so that a swapped byte or
    // a one/zero mix-up shows up.
    wait_drained();
    program_regs(32'h80FF_017F, 16'd9000, 16'd4500, 16'd560, 16'd1680, 16'd561);
    send_frame(OP_ID_ONE, 12'h000, 12'h000);
    send_frame(OP_ID_TWO, 12'h000, 12'h000);

    // Random phases, each under its own register setting. One phase sends with
    // no gaps at all so the request queue runs full for a long stretch; the
    // others leave gaps in about a quarter of the words, now and then long
    // enough to let the serializer go idle.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      program_regs(pick_device_id(), pick_duration(), pick_duration(), pick_duration(),
                   pick_duration(), pick_duration());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_frame(pick_kind(), pick_sample(), pick_sample());
        if (phase != STEADY_PHASE && $urandom_range(0, 99) < 23) begin
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(35, 110) : $urandom_range(1, 12);
          hold_off(gap);
        end
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && pending_pairs == 0) begin
      $display("ir_beacon_frame_transmitter test passed");
    end else begin
      $display("ir_beacon_frame_transmitter test failed");
    end
    $finish;
  end

  // Ends the run if no request, word or register write moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || pair_valid || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("ir_beacon_frame_transmitter test failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/irb_pkg.sv
rtl/irb_front.sv
rtl/irb_fifo.sv
rtl/irb_back.sv
rtl/ir_beacon_frame_transmitter.sv
tb/sv/irb_frame_checker.sv
tb/sv/testbench.sv
